// ===== rtl/sipep_pkg.sv =====
// Package for the SipHash edge endpoint generator.
// Holds the SipHash state type, constants, register indexes and half-round functions.
// No dependencies.
package sipep_pkg;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } sip_state_t;

  localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
  localparam logic [63:0] SIP_FINAL_XOR = 64'h00000000000000ff;

  localparam int unsigned NODE_W = 31;
  localparam logic [NODE_W-1:0] NODE_MASK_RST = {NODE_W{1'b1}};

  // 2 compression rounds + 4 finalization rounds, two stages per round
  localparam int unsigned NUM_ROUNDS = 6;
  localparam int unsigned NUM_STAGES = 2 * NUM_ROUNDS;
  // stage whose input gets the end-of-compression xors
  localparam int unsigned FINAL_STAGE = 4;

  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LOW   = 2'd0,
    REG_KEY_HIGH  = 2'd1,
    REG_NODE_MASK = 2'd2
  } cfg_reg_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
    rotl = (x << r) | (x >> (64 - r));
  endfunction

  // first half of a SipRound
  function automatic sip_state_t half_a(input sip_state_t s);
    sip_state_t o;
    logic [63:0] a0;
    logic [63:0] a2;
    a0   = s.v0 + s.v1;
    a2   = s.v2 + s.v3;
    o.v1 = rotl(s.v1, 13) ^ a0;
    o.v0 = rotl(a0, 32);
    o.v3 = rotl(s.v3, 16) ^ a2;
    o.v2 = a2;
    return o;
  endfunction

  // second half of a SipRound
  function automatic sip_state_t half_b(input sip_state_t s);
    sip_state_t o;
    logic [63:0] a0;
    logic [63:0] a2;
    a0   = s.v0 + s.v3;
    a2   = s.v2 + s.v1;
    o.v3 = rotl(s.v3, 21) ^ a0;
    o.v0 = a0;
    o.v1 = rotl(s.v1, 17) ^ a2;
    o.v2 = rotl(a2, 32);
    return o;
  endfunction

endpackage

// ===== rtl/siphash_edge_endpoint.sv =====
// Top level of the SipHash edge endpoint generator.
// Depends on sipep_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one transaction per edge endpoint,
//   carrying in_edge_index and in_endpoint_side. Output channel
//   (out_valid / out_stall): one transaction per input, in order, carrying
//   out_node_id = ((siphash(2*index+side) & node_mask) << 1) | side.
//   Config channel (cfg_valid / cfg_ready): cfg_index selects key_low (0),
//   key_high (1) or node_mask (2); other indexes are dropped. cfg_ready is
//   always high. Write config only while the pipeline is empty.
// Timing:
//   Each half SipRound is one register stage, 12 stages, plus the output
//   register; throughput is one transaction per cycle while out_stall is low.
//   Each stage holds its item while the next is full and stalled, and an
//   empty stage takes a new one, so bubbles are squeezed out. in_stall rises
//   only once every stage and the output register hold data and out_stall
//   is high.
// Reset:
//   rst_n is synchronous; it empties the pipeline, clears the key and sets
//   node_mask to all ones.
module siphash_edge_endpoint
  import sipep_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          in_edge_index,
  input  logic                 in_endpoint_side,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          out_node_id,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  logic [63:0]       key_low_r;
  logic [63:0]       key_high_r;
  logic [NODE_W-1:0] node_mask_r;

  sip_state_t        st_r   [NUM_STAGES];
  logic [31:0]       msg_r  [NUM_STAGES];
  logic              vld_r  [NUM_STAGES];
  logic              ready  [NUM_STAGES+1];

  logic              out_valid_r;
  logic [31:0]       out_node_id_r;
  logic [31:0]       in_msg;
  logic [63:0]       hash;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r   <= '0;
      key_high_r  <= '0;
      node_mask_r <= NODE_MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY_LOW:   key_low_r   <= cfg_data;
        REG_KEY_HIGH:  key_high_r  <= cfg_data;
        REG_NODE_MASK: node_mask_r <= cfg_data[NODE_W-1:0];
        default: ;
      endcase
    end
  end

  // 2*index + side, mod 2^32
  assign in_msg = {in_edge_index[30:0], in_endpoint_side};

  always_comb begin
    ready[NUM_STAGES] = !out_valid_r || !out_stall;
    for (int s = NUM_STAGES - 1; s >= 0; s--) begin
      ready[s] = !vld_r[s] || ready[s+1];
    end
  end

  assign in_stall = !ready[0];

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    sip_state_t  st_in;
    sip_state_t  st_nxt;
    logic        vld_in;
    logic [31:0] msg_in;

    if (s == 0) begin : g_first
      assign vld_in = in_valid;
      assign msg_in = in_msg;
      assign st_in  = '{v0: key_low_r ^ SIP_C0,
                        v1: key_high_r ^ SIP_C1,
                        v2: key_low_r ^ SIP_C2,
                        v3: key_high_r ^ SIP_C3 ^ {32'd0, in_msg}};
    end else if (s == FINAL_STAGE) begin : g_fin
      assign vld_in = vld_r[s-1];
      assign msg_in = msg_r[s-1];
      assign st_in  = '{v0: st_r[s-1].v0 ^ {32'd0, msg_r[s-1]},
                        v1: st_r[s-1].v1,
                        v2: st_r[s-1].v2 ^ SIP_FINAL_XOR,
                        v3: st_r[s-1].v3};
    end else begin : g_mid
      assign vld_in = vld_r[s-1];
      assign msg_in = msg_r[s-1];
      assign st_in  = st_r[s-1];
    end

    if (s % 2 == 0) begin : g_ha
      assign st_nxt = half_a(st_in);
    end else begin : g_hb
      assign st_nxt = half_b(st_in);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (ready[s]) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ready[s] && vld_in) begin
        st_r[s]  <= st_nxt;
        msg_r[s] <= msg_in;
      end
    end
  end

  assign hash = st_r[NUM_STAGES-1].v0 ^ st_r[NUM_STAGES-1].v1 ^
                st_r[NUM_STAGES-1].v2 ^ st_r[NUM_STAGES-1].v3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ready[NUM_STAGES]) begin
      out_valid_r <= vld_r[NUM_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ready[NUM_STAGES] && vld_r[NUM_STAGES-1]) begin
      out_node_id_r <= {hash[NODE_W-1:0] & node_mask_r, msg_r[NUM_STAGES-1][0]};
    end
  end

  assign out_valid   = out_valid_r;
  assign out_node_id = out_node_id_r;

endmodule

// ===== rtl/sipep_checker.sv =====
// Port-level checker for siphash_edge_endpoint, attached by bind.
// Watches only handshake and result ports; no package dependencies.
module sipep_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_node_id,
  input logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_node_id))
    else $error("stalled output transaction changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output is free");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind siphash_edge_endpoint sipep_checker u_sipep_checker (.*);
